### src/ddo_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and lookup functions for the wheel odometry block
// no dependencies; imported by every module of the block
package ddo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int WRAP_STEPS   = 4;
    localparam int CNT_W        = 5;

    localparam logic [23:0]        INV_TRACK_RESET = 24'd218453;
    localparam logic [55:0]        TWO_PI_W        = 56'd1686629713;
    // floor(2^56 / two pi in Q4.28)
    localparam logic [25:0]        TWO_PI_RECIP    = 26'd42722829;
    localparam logic signed [32:0] TWO_PI_Q28      = 33'sd1686629713;
    localparam logic signed [32:0] PI_Q28          = 33'sd843314857;
    localparam logic signed [32:0] HALF_PI_Q28     = 33'sd421657428;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // phases of the heading wrap, counted down by the sequencer
    localparam logic [CNT_W-1:0] WRAP_RECIP = 5'd3;
    localparam logic [CNT_W-1:0] WRAP_QMUL  = 5'd2;
    localparam logic [CNT_W-1:0] WRAP_SUB   = 5'd1;
    localparam logic [CNT_W-1:0] WRAP_FIX   = 5'd0;

    typedef enum logic [1:0] {
        MUL_HEAD  = 2'd0,
        MUL_SPEED = 2'd1,
        MUL_COS   = 2'd2,
        MUL_SIN   = 2'd3
    } mul_sel_t;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_HMUL = 12'b000000000010,
        S_HADD = 12'b000000000100,
        S_WRAP = 12'b000000001000,
        S_ROT  = 12'b000000010000,
        S_CORD = 12'b000000100000,
        S_XMUL = 12'b000001000000,
        S_XADD = 12'b000010000000,
        S_YMUL = 12'b000100000000,
        S_YADD = 12'b001000000000,
        S_SMUL = 12'b010000000000,
        S_SOUT = 12'b100000000000
    } state_t;

    typedef struct packed {
        logic             load_in;
        logic             mul_en;
        mul_sel_t         mul_sel;
        logic             head_add;
        logic             wrap_step;
        logic             rot_init;
        logic             cordic_step;
        logic             x_add;
        logic             y_add;
        logic             commit;
        logic             load_out;
        logic [CNT_W-1:0] step_idx;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    // atan(2^-i) in Q4.28, rounded
    function automatic logic signed [32:0] atan_q28(input logic [CNT_W-1:0] i);
        logic signed [32:0] r;
        case (i)
            5'd0:  r = 33'sd210828714;
            5'd1:  r = 33'sd124459457;
            5'd2:  r = 33'sd65760959;
            5'd3:  r = 33'sd33381290;
            5'd4:  r = 33'sd16755422;
            5'd5:  r = 33'sd8385879;
            5'd6:  r = 33'sd4193963;
            5'd7:  r = 33'sd2097109;
            5'd8:  r = 33'sd1048571;
            5'd9:  r = 33'sd524287;
            5'd10: r = 33'sd262144;
            5'd11: r = 33'sd131072;
            5'd12: r = 33'sd65536;
            5'd13: r = 33'sd32768;
            5'd14: r = 33'sd16384;
            5'd15: r = 33'sd8192;
            5'd16: r = 33'sd4096;
            5'd17: r = 33'sd2048;
            5'd18: r = 33'sd1024;
            5'd19: r = 33'sd512;
            5'd20: r = 33'sd256;
            5'd21: r = 33'sd128;
            5'd22: r = 33'sd64;
            5'd23: r = 33'sd32;
            5'd24: r = 33'sd16;
            5'd25: r = 33'sd8;
            5'd26: r = 33'sd4;
            5'd27: r = 33'sd2;
            default: r = 33'sd0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [51:0] v);
        logic [31:0] r;
        if (v > 52'sd2147483647)
            r = 32'h7fffffff;
        else if (v < -52'sd2147483648)
            r = 32'h80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

### src/ddo_ctrl.sv
`timescale 1ns / 1ps
// sequencer for the odometry update: steps the datapath through heading,
// wrap, cordic, position and speed phases; uses ddo_pkg
module ddo_ctrl
    import ddo_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_op,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.mul_sel  = MUL_HEAD;
        cmd.step_idx = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = in_op ? S_SMUL : S_HMUL;
                end
            end
            S_HMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_HEAD;
                state_next  = S_HADD;
            end
            S_HADD:
            begin
                cmd.head_add = 1'b1;
                cnt_next     = CNT_W'(WRAP_STEPS - 1);
                state_next   = S_WRAP;
            end
            S_WRAP:
            begin
                cmd.wrap_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = S_ROT;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_ROT:
            begin
                cmd.rot_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_CORD;
            end
            S_CORD:
            begin
                cmd.cordic_step = 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                    state_next = S_XMUL;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_XMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_COS;
                state_next  = S_XADD;
            end
            S_XADD:
            begin
                cmd.x_add  = 1'b1;
                state_next = S_YMUL;
            end
            S_YMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SIN;
                state_next  = S_YADD;
            end
            S_YADD:
            begin
                cmd.y_add  = 1'b1;
                state_next = S_SMUL;
            end
            S_SMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SPEED;
                cmd.commit  = 1'b1;
                state_next  = S_SOUT;
            end
            S_SOUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### src/ddo_datapath.sv
`timescale 1ns / 1ps
// odometry datapath: pose state, shared multiplier, heading wrap unit,
// cordic rotator and output register; uses ddo_pkg
module ddo_datapath
    import ddo_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    input  logic [23:0]  cfg_data,
    input  logic [223:0] in_data,
    input  logic         in_op,
    input  cmd_t         cmd,
    output status_t      status,
    input  logic         out_ready,
    output logic         out_valid,
    output logic [159:0] out_data
);

    logic [23:0]        inv_reg;
    logic               op_reg;
    logic signed [31:0] ld_reg, rd_reg, ls_reg, rs_reg, nx_reg, ny_reg, nh_reg;
    logic signed [31:0] last_l_reg, last_r_reg;
    logic signed [31:0] acc_x_reg, acc_y_reg, acc_h_reg;
    logic signed [32:0] travel_reg;
    logic signed [67:0] prod_reg, prod_next;
    logic [55:0]        hmag_reg;
    logic               hsign_reg;
    logic [57:0]        wq_reg, wq_next;
    logic [55:0]        qp_reg, qp_next;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;
    logic               flip_reg;
    logic               out_valid_reg;
    logic [159:0]       out_data_reg;

    // increments at 33 bits, difference at 34
    logic signed [32:0] dl, dr, sd;
    logic signed [33:0] dd, tsum, mul_a, mul_b, cos_val, sin_val;
    logic signed [32:0] ssum;
    logic signed [31:0] lin;
    logic signed [55:0] hsum;
    logic signed [31:0] hw;
    logic signed [32:0] z0, z1, z2;
    logic               flip;
    logic signed [33:0] xs, ys;
    logic signed [32:0] at;
    logic signed [38:0] sx, sy;

    always_comb
    begin
        dl      = 33'(ld_reg) - 33'(last_l_reg);
        dr      = 33'(rd_reg) - 33'(last_r_reg);
        dd      = 34'(dr) - 34'(dl);
        tsum    = 34'(dl) + 34'(dr);
        sd      = 33'(rs_reg) - 33'(ls_reg);
        cos_val = flip_reg ? -cx_reg : cx_reg;
        sin_val = flip_reg ? -cy_reg : cy_reg;
        mul_b   = $signed({10'b0, inv_reg});
        case (cmd.mul_sel)
            MUL_HEAD:  mul_a = dd;
            MUL_SPEED: mul_a = 34'(sd);
            MUL_COS:
            begin
                mul_a = 34'(travel_reg);
                mul_b = cos_val;
            end
            default:
            begin
                mul_a = 34'(travel_reg);
                mul_b = sin_val;
            end
        endcase
        prod_next = 68'(mul_a) * 68'(mul_b);
    end

    // truncating halves: add one before the shift when negative
    always_comb
    begin
        ssum = 33'(ls_reg) + 33'(rs_reg);
        lin  = 32'((ssum + 33'($unsigned(ssum[32]))) >>> 1);
    end

    always_comb
    begin
        hsum     = 56'(acc_h_reg) + $signed(prod_reg[59:4]);
        // quotient estimate from the top bits, at most one turn short
        wq_next  = 58'(hmag_reg[55:24]) * 58'(TWO_PI_RECIP);
        qp_next  = 56'(wq_reg[57:32]) * TWO_PI_W;
        hw       = hsign_reg ? -$signed(hmag_reg[31:0]) : $signed(hmag_reg[31:0]);
        z0       = 33'(hw);
        if (z0 > PI_Q28)
            z1 = z0 - TWO_PI_Q28;
        else if (z0 < -PI_Q28)
            z1 = z0 + TWO_PI_Q28;
        else
            z1 = z0;
        flip = 1'b1;
        if (z1 > HALF_PI_Q28)
            z2 = z1 - PI_Q28;
        else if (z1 < -HALF_PI_Q28)
            z2 = z1 + PI_Q28;
        else
        begin
            z2   = z1;
            flip = 1'b0;
        end
        xs = cx_reg >>> cmd.step_idx;
        ys = cy_reg >>> cmd.step_idx;
        at = atan_q28(cmd.step_idx);
        sx = 39'(acc_x_reg) + 39'($signed(prod_reg[67:30]));
        sy = 39'(acc_y_reg) + 39'($signed(prod_reg[67:30]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg       <= INV_TRACK_RESET;
            last_l_reg    <= '0;
            last_r_reg    <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            acc_h_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                inv_reg <= cfg_data;
            if (cmd.rot_init)
                acc_h_reg <= hw;
            if (cmd.x_add)
                acc_x_reg <= sat32(52'(sx));
            if (cmd.y_add)
                acc_y_reg <= sat32(52'(sy));
            if (cmd.commit)
            begin
                last_l_reg <= ld_reg;
                last_r_reg <= rd_reg;
                if (op_reg)
                begin
                    acc_x_reg <= nx_reg;
                    acc_y_reg <= ny_reg;
                    acc_h_reg <= nh_reg;
                end
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg <= in_op;
            ld_reg <= in_data[31:0];
            rd_reg <= in_data[63:32];
            ls_reg <= in_data[95:64];
            rs_reg <= in_data[127:96];
            nx_reg <= in_data[159:128];
            ny_reg <= in_data[191:160];
            nh_reg <= in_data[223:192];
        end
        if (cmd.mul_en)
            prod_reg <= prod_next;
        if (cmd.head_add)
        begin
            travel_reg <= 33'((tsum + 34'($unsigned(tsum[33]))) >>> 1);
            hsign_reg  <= hsum[55];
            hmag_reg   <= hsum[55] ? 56'(-hsum) : 56'(hsum);
        end
        // remainder by two pi: reciprocal multiply, back-multiply, subtract, fix up
        if (cmd.wrap_step)
        begin
            case (cmd.step_idx)
                WRAP_RECIP: wq_reg <= wq_next;
                WRAP_QMUL:  qp_reg <= qp_next;
                WRAP_SUB:   hmag_reg <= hmag_reg - qp_reg;
                default:
                begin
                    if (hmag_reg >= TWO_PI_W)
                        hmag_reg <= hmag_reg - TWO_PI_W;
                end
            endcase
        end
        if (cmd.rot_init)
        begin
            cx_reg   <= CORDIC_GAIN_Q30;
            cy_reg   <= '0;
            cz_reg   <= z2;
            flip_reg <= flip;
        end
        if (cmd.cordic_step)
        begin
            if (cz_reg >= 0)
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - at;
            end
            else
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + at;
            end
        end
        if (cmd.load_out)
            out_data_reg <= {sat32(52'($signed(prod_reg[67:16]))), lin,
                             acc_h_reg, acc_y_reg, acc_x_reg};
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

    a_wrap_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rot_init |-> (hmag_reg < TWO_PI_W))
        else $error("heading remainder not below two pi");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rot_init |=> (acc_h_reg < 32'sd1686629713 && acc_h_reg > -32'sd1686629713))
        else $error("wrapped heading out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before taken");

endmodule

### src/differential_drive_odometry.sv
`timescale 1ns / 1ps
// Differential-drive wheel odometry. A wheel sample beat passes, after acceptance,
// through the heading multiply and add, the remainder by two pi (reciprocal
// multiply, quotient multiply, subtract, one fix-up), the quadrant reduction,
// 16 cordic rotations, the x and y multiply-accumulate and the speed product
// and result load; a set-pose beat goes straight to the speed product and result
// load. The next beat is accepted the cycle after the result is loaded, and one
// item is in work at a time; the next is accepted while the previous result waits
// in the output register, and a finished result that finds that register still
// full holds the block until it is taken.
// Depends on ddo_pkg, ddo_ctrl and ddo_datapath.
module differential_drive_odometry
    import ddo_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [23:0]  cfg_data,       // inv_track_width
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // wheel_left_dist, wheel_right_dist, wheel_left_speed, wheel_right_speed,
    // new_x, new_y, new_heading
    input  logic [223:0] s_axis_tdata,
    input  logic         s_axis_tuser,   // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pose_x, pose_y, pose_heading, speed_linear, speed_angular
    output logic [159:0] m_axis_tdata
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    ddo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ddo_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_op     (s_axis_tuser),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

endmodule
